// File: src/nt_password_hash_match_assert.svh
// Assertion macros used by the checker file of the hash match block.
`ifndef NT_PASSWORD_HASH_MATCH_ASSERT_SVH
`define NT_PASSWORD_HASH_MATCH_ASSERT_SVH

// Check a property on every rising clock edge outside of reset.
`define NPHM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nphm check failed");

// Check a property on every rising clock edge, reset cycles included.
`define NPHM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("nphm check failed during reset");

`endif

// File: src/nphm_pkg.sv
// Types, constants and step tables of the single-block NT hash pipeline.
package nphm_pkg;

   localparam int unsigned STEPS      = 48;
   localparam int unsigned BLOCK_WORDS = 16;

   typedef logic [31:0] word_type;

   // working variables handed from cell to cell
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } chain_type;

   // one 512-bit message block, word 0 in the low bits
   typedef logic [BLOCK_WORDS-1:0][31:0] block_type;

   localparam word_type IV_A = 32'h67452301;
   localparam word_type IV_B = 32'hefcdab89;
   localparam word_type IV_C = 32'h98badcfe;
   localparam word_type IV_D = 32'h10325476;

   localparam word_type K_ROUND_G = 32'h5a827999;
   localparam word_type K_ROUND_H = 32'h6ed9eba1;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // round codes
   localparam logic [1:0] ROUND_F = 2'd0;
   localparam logic [1:0] ROUND_G = 2'd1;
   localparam logic [1:0] ROUND_H = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_TARGET_A = 2'd0;
   localparam logic [1:0] REG_TARGET_B = 2'd1;
   localparam logic [1:0] REG_TARGET_C = 2'd2;
   localparam logic [1:0] REG_TARGET_D = 2'd3;

   // message word used by each step
   localparam logic [3:0] MSG_INDEX [STEPS] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
      4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
      4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
      4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
      4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
   };

   // rotate amounts, four per round
   localparam logic [4:0] ROT_AMOUNT [12] = '{
      5'd3, 5'd7, 5'd11, 5'd19,
      5'd3, 5'd5, 5'd9, 5'd13,
      5'd3, 5'd9, 5'd11, 5'd15
   };

   // boolean mixing function of each round
   function automatic word_type mix(input logic [1:0] rnd, input word_type x,
                                    input word_type y, input word_type z);
      word_type res;
      unique case (rnd)
         ROUND_F: res = z ^ (x & (y ^ z));
         ROUND_G: res = (x & (y | z)) | (y & z);
         default: res = x ^ y ^ z;
      endcase
      return res;
   endfunction

endpackage

// File: src/nphm_block.sv
// Front cell: packs the candidate characters into the padded message block.
module nphm_block import nphm_pkg::*; #(
   parameter int unsigned MAX_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [63:0] text_first,
   input  logic [63:0] text_second,
   input  logic [4:0]  text_length,
   output logic        out_valid,
   output block_type   out_blk
);

   logic            valid_ff;
   block_type       blk_ff;
   block_type       blk_in;
   logic [4:0]      len_sat;
   logic [15:0][7:0] chars;
   logic [7:0]      bytes [64];

   assign chars = {text_second, text_first};

   // clamp the length to the supported count
   always_comb begin
      if (text_length > 5'(MAX_CHARS)) begin
         len_sat = 5'(MAX_CHARS);
      end else begin
         len_sat = text_length;
      end
   end

   // place code units, pad byte and bit length
   always_comb begin
      for (int j = 0; j < 64; j++) begin
         bytes[j] = 8'h00;
         if ((j % 2) == 0 && (j / 2) < 16 && 5'(j / 2) < len_sat) begin
            bytes[j] = chars[4'(j / 2)];
         end else if (6'(j) == {len_sat, 1'b0}) begin
            bytes[j] = PAD_BYTE;
         end
      end
      for (int w = 0; w < 16; w++) begin
         blk_in[w] = {bytes[4*w+3], bytes[4*w+2], bytes[4*w+1], bytes[4*w]};
      end
      blk_in[14] = {23'd0, len_sat, 4'd0};
   end

   // hold while the chain is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

// File: src/nphm_step_cell.sv
// One compression step: a single add-rotate update of the working variables.
module nphm_step_cell import nphm_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  chain_type in_chain,
   input  block_type in_blk,
   output logic      out_valid,
   output chain_type out_chain,
   output block_type out_blk
);

   localparam logic [1:0] RND = 2'(STEP / 16);
   localparam logic [3:0] IDX = MSG_INDEX[STEP];
   localparam logic [4:0] ROT = ROT_AMOUNT[(STEP / 16) * 4 + (STEP % 4)];
   localparam int unsigned ROT_BACK = 32 - int'(ROT);
   localparam word_type K_STEP = (RND == ROUND_F) ? 32'd0 :
                                 (RND == ROUND_G) ? K_ROUND_G : K_ROUND_H;

   logic      valid_ff;
   chain_type chain_ff;
   block_type blk_ff;
   chain_type chain_in;
   word_type  sum;
   word_type  rotated;

   // add, rotate and shift the variables along
   always_comb begin
      sum = in_chain.a + mix(RND, in_chain.b, in_chain.c, in_chain.d) + in_blk[IDX] + K_STEP;
      rotated = (sum << ROT) | (sum >> ROT_BACK);
      chain_in.a = in_chain.d;
      chain_in.b = rotated;
      chain_in.c = in_chain.b;
      chain_in.d = in_chain.c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chain_ff <= chain_in;
         blk_ff   <= in_blk;
      end
   end

   assign out_valid = valid_ff;
   assign out_chain = chain_ff;
   assign out_blk   = blk_ff;

endmodule

// File: src/nphm_out.sv
// Output register: adds the chaining values back and compares with the targets.
module nphm_out import nphm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  chain_type in_chain,
   input  chain_type target,
   output logic      out_valid,
   output chain_type out_digest,
   output logic      out_match
);

   logic      valid_ff;
   chain_type digest_ff;
   logic      match_ff;
   chain_type digest_in;

   // feed-forward addition
   always_comb begin
      digest_in.a = in_chain.a + IV_A;
      digest_in.b = in_chain.b + IV_B;
      digest_in.c = in_chain.c + IV_C;
      digest_in.d = in_chain.d + IV_D;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         digest_ff <= digest_in;
         match_ff  <= (digest_in == target);
      end
   end

   assign out_valid  = valid_ff;
   assign out_digest = digest_ff;
   assign out_match  = match_ff;

endmodule

// File: src/nt_password_hash_match.sv
// Top level: NT password hash over a row of 48 step cells with a target match.
//
//   channel   dir   handshake            payload
//   req       in    req_tvalid/tready    text_first, text_second, text_length
//   rsp       out   rsp_tvalid/tready    digest_a..d, is_match in tuser
//   csr       in    csr_we               csr_index, csr_wdata
//
// One request enters per cycle while no result is held; each result passes the packing
// register, which loads on the edge that takes its request, then 48 step cells and
// the output register, where it is offered.
// A held result freezes the whole row of cells and drops req_tready.
// Reset clears every valid bit and the four target words.
module nt_password_hash_match import nphm_pkg::*; #(
   parameter int unsigned MAX_CHARS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // text_first[63:0], text_second[127:64], text_length[132:128], zero fill
   input  logic [135:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // digest_a[31:0], digest_b[63:32], digest_c[95:64], digest_d[127:96]
   output logic [127:0] rsp_tdata,
   // is_match[0]
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic      advance;
   chain_type target_ff;
   chain_type digest;
   logic      match;

   logic      stage_valid [STEPS+1];
   chain_type stage_chain [STEPS+1];
   block_type stage_blk   [STEPS+1];

   // move the row whenever the output register can take a new result
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // target register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_A: target_ff.a <= csr_wdata;
            REG_TARGET_B: target_ff.b <= csr_wdata;
            REG_TARGET_C: target_ff.c <= csr_wdata;
            REG_TARGET_D: target_ff.d <= csr_wdata;
         endcase
      end
   end

   nphm_block #(
      .MAX_CHARS (MAX_CHARS)
   ) u_block (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_tvalid),
      .text_first  (req_tdata[63:0]),
      .text_second (req_tdata[127:64]),
      .text_length (req_tdata[132:128]),
      .out_valid   (stage_valid[0]),
      .out_blk     (stage_blk[0])
   );

   assign stage_chain[0] = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

   // row of step cells
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      nphm_step_cell #(
         .STEP (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[k]),
         .in_chain  (stage_chain[k]),
         .in_blk    (stage_blk[k]),
         .out_valid (stage_valid[k+1]),
         .out_chain (stage_chain[k+1]),
         .out_blk   (stage_blk[k+1])
      );
   end

   nphm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (stage_valid[STEPS]),
      .in_chain   (stage_chain[STEPS]),
      .target     (target_ff),
      .out_valid  (rsp_tvalid),
      .out_digest (digest),
      .out_match  (match)
   );

   assign rsp_tdata = {digest.d, digest.c, digest.b, digest.a};
   assign rsp_tuser = match;

endmodule

// File: src/nphm_checker.sv
// Port-level checker for the hash match block, bound to the top level.
`include "nt_password_hash_match_assert.svh"

module nphm_checker import nphm_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic [135:0] req_tdata,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] rsp_tdata,
   input logic [0:0]   rsp_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic         csr_we,
   input logic [1:0]   csr_index,
   input logic [31:0]  csr_wdata
);

   logic [127:0] target_ff;

   // track the target words as written on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_A: target_ff[31:0]   <= csr_wdata;
            REG_TARGET_B: target_ff[63:32]  <= csr_wdata;
            REG_TARGET_C: target_ff[95:64]  <= csr_wdata;
            REG_TARGET_D: target_ff[127:96] <= csr_wdata;
         endcase
      end
   end

   `NPHM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid)
   `NPHM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `NPHM_ASSERT(a_match_flag, clock, reset, rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata == target_ff)))
   `NPHM_ASSERT(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready)

endmodule

bind nt_password_hash_match nphm_checker u_nphm_checker (.*);
